### rtl/core/lkbs_pkg.sv
// shared types and constants of the lru keyed block store
`default_nettype none

package lkbs_pkg;

    localparam int OP_W    = 3;
    localparam int CAP_W   = 5;
    localparam int TOT_W   = 32;
    localparam int FLAGS_W = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;
    localparam logic [TOT_W-1:0] TOT_MAX   = {TOT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_PUT      = 3'd0,
        OP_GET      = 3'd1,
        OP_REMOVE   = 3'd2,
        OP_CONTAINS = 3'd3,
        OP_EVICT    = 3'd4,
        OP_PEEK     = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_APPLY
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic look;
        logic apply;
    } t_cmd;

endpackage

`default_nettype wire

### rtl/core/lkbs_ctrl.sv
// controller state machine: request sequencing and result handshake
`default_nettype none

module lkbs_ctrl (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_req_valid,
    output logic              o_req_ready,
    output logic              o_res_valid,
    input  wire               i_res_ready,
    output lkbs_pkg::t_cmd    o_cmd
);
    import lkbs_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_res_valid;
    logic   n_res_valid;
    logic   can_apply;
    logic   accept;

    assign can_apply = !r_res_valid || i_res_ready;
    assign accept    = i_req_valid && o_req_ready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) n_state = ST_LOOK;
            end
            ST_LOOK: begin
                n_state = ST_APPLY;
            end
            ST_APPLY: begin
                if (can_apply) n_state = accept ? ST_LOOK : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
            end
            ST_LOOK: begin
                o_cmd.look = 1'b1;
            end
            ST_APPLY: begin
                // next request may enter while this one is committed
                o_req_ready = can_apply;
                o_cmd.apply = can_apply;
            end
            default: o_req_ready = 1'b0;
        endcase
        o_cmd.load = i_req_valid && o_req_ready;
    end

    always_comb begin
        if (o_cmd.apply) begin
            n_res_valid = 1'b1;
        end else if (i_res_ready) begin
            n_res_valid = 1'b0;
        end else begin
            n_res_valid = r_res_valid;
        end
    end

    assign o_res_valid = r_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= n_res_valid;
        end
    end

endmodule

`default_nettype wire

### rtl/core/lkbs_datapath.sv
// slot array with parallel key compare, age update and result register
`default_nettype none

module lkbs_datapath #(
    parameter  int DEPTH     = 16,
    parameter  int KEY_BITS  = 32,
    parameter  int DATA_BITS = 32,
    localparam int OCC_W     = $clog2(DEPTH + 1)
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  lkbs_pkg::t_cmd              i_cmd,
    input  wire                         i_cfg_we,
    input  wire  [lkbs_pkg::CAP_W-1:0]  i_cfg_data,
    input  wire  [lkbs_pkg::OP_W-1:0]   i_op,
    input  wire  [KEY_BITS-1:0]         i_key,
    input  wire  [DATA_BITS-1:0]        i_payload,
    output logic                        o_found,
    output logic [DATA_BITS-1:0]        o_data_out,
    output logic                        o_victim_valid,
    output logic [KEY_BITS-1:0]         o_victim_key,
    output logic [OCC_W-1:0]            o_occupancy,
    output logic [lkbs_pkg::TOT_W-1:0]  o_eviction_total
);
    import lkbs_pkg::*;

    localparam int IW    = $clog2(DEPTH);
    localparam int CMP_W = (CAP_W > OCC_W) ? CAP_W : OCC_W;

    // request registers
    logic [OP_W-1:0]      r_op;
    logic [KEY_BITS-1:0]  r_key;
    logic [DATA_BITS-1:0] r_payload;

    // slot array
    logic                 r_valid [DEPTH];
    logic [KEY_BITS-1:0]  r_skey  [DEPTH];
    logic [DATA_BITS-1:0] r_sdata [DEPTH];
    logic [IW-1:0]        r_age   [DEPTH];

    logic [OCC_W-1:0]     r_occ;
    logic [TOT_W-1:0]     r_evictions;
    logic [CAP_W-1:0]     r_cap;

    // lookup results
    logic                 r_hit;
    logic [IW-1:0]        r_hit_idx;
    logic [IW-1:0]        r_hit_age;
    logic [DATA_BITS-1:0] r_hit_data;
    logic                 r_old_ok;
    logic [IW-1:0]        r_old_idx;
    logic [KEY_BITS-1:0]  r_old_key;
    logic [DATA_BITS-1:0] r_old_data;
    logic [IW-1:0]        r_free_idx;

    logic                 hit;
    logic [IW-1:0]        hit_idx;
    logic [IW-1:0]        hit_age;
    logic [DATA_BITS-1:0] hit_data;
    logic                 old_ok;
    logic [IW-1:0]        old_idx;
    logic [KEY_BITS-1:0]  old_key;
    logic [DATA_BITS-1:0] old_data;
    logic [IW-1:0]        free_idx;
    logic [OCC_W-1:0]     occ_m1;

    // keys and ages are unique among valid slots, so hit and oldest are at most one-hot
    always_comb begin
        hit      = 1'b0;
        hit_idx  = '0;
        hit_age  = '0;
        hit_data = '0;
        old_ok   = 1'b0;
        old_idx  = '0;
        old_key  = '0;
        old_data = '0;
        free_idx = '0;
        occ_m1   = r_occ - OCC_W'(1);
        for (int i = 0; i < DEPTH; i++) begin
            if (r_valid[i] && r_skey[i] == r_key) begin
                hit      = 1'b1;
                hit_idx  = hit_idx | IW'(i);
                hit_age  = hit_age | r_age[i];
                hit_data = hit_data | r_sdata[i];
            end
            if (r_valid[i] && r_occ != '0 && r_age[i] == occ_m1[IW-1:0]) begin
                old_ok   = 1'b1;
                old_idx  = old_idx | IW'(i);
                old_key  = old_key | r_skey[i];
                old_data = old_data | r_sdata[i];
            end
        end
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (!r_valid[i]) free_idx = IW'(i);
        end
    end

    // commit stage
    logic [CMP_W-1:0] cap_x;
    logic [CMP_W-1:0] cap_eff;
    logic             full;
    logic             is_put;
    logic             is_get;
    logic             is_remove;
    logic             is_contains;
    logic             is_evict;
    logic             is_peek;
    logic             do_touch;
    logic             do_drop;
    logic             do_evict;
    logic             do_insert;
    logic [IW-1:0]    ins_idx;

    logic                 n_valid   [DEPTH];
    logic [IW-1:0]        n_age     [DEPTH];
    logic                 we_key    [DEPTH];
    logic                 we_data   [DEPTH];
    logic [OCC_W-1:0]     n_occ;
    logic [TOT_W-1:0]     n_evictions;
    logic                 res_found;
    logic [DATA_BITS-1:0] res_data;

    always_comb begin
        cap_x   = CMP_W'(r_cap);
        cap_eff = cap_x;
        if (cap_x == '0) begin
            cap_eff = CMP_W'(1);
        end else if (cap_x > CMP_W'(DEPTH)) begin
            cap_eff = CMP_W'(DEPTH);
        end
        full = CMP_W'(r_occ) >= cap_eff;
    end

    always_comb begin
        is_put      = r_op == OP_PUT;
        is_get      = r_op == OP_GET;
        is_remove   = r_op == OP_REMOVE;
        is_contains = r_op == OP_CONTAINS;
        is_evict    = r_op == OP_EVICT;
        is_peek     = r_op == OP_PEEK;

        do_touch  = (is_put || is_get) && r_hit;
        do_drop   = is_remove && r_hit;
        do_evict  = (is_put && !r_hit && full) || (is_evict && r_old_ok);
        do_insert = is_put && !r_hit;
        ins_idx   = do_evict ? r_old_idx : r_free_idx;

        for (int i = 0; i < DEPTH; i++) begin
            n_valid[i] = r_valid[i];
            n_age[i]   = r_age[i];
            we_key[i]  = 1'b0;
            we_data[i] = 1'b0;
            if (do_touch) begin
                if (r_valid[i] && r_age[i] < r_hit_age) n_age[i] = r_age[i] + IW'(1);
                if (IW'(i) == r_hit_idx) n_age[i] = '0;
                if (is_put && IW'(i) == r_hit_idx) we_data[i] = 1'b1;
            end
            if (do_drop) begin
                if (IW'(i) == r_hit_idx) begin
                    n_valid[i] = 1'b0;
                end else if (r_valid[i] && r_age[i] > r_hit_age) begin
                    n_age[i] = r_age[i] - IW'(1);
                end
            end
            // the victim is always the oldest, so no other age moves down
            if (do_evict && IW'(i) == r_old_idx) n_valid[i] = 1'b0;
            if (do_insert) begin
                if (r_valid[i] && !(do_evict && IW'(i) == r_old_idx)) begin
                    n_age[i] = r_age[i] + IW'(1);
                end
                if (IW'(i) == ins_idx) begin
                    n_valid[i] = 1'b1;
                    n_age[i]   = '0;
                    we_key[i]  = 1'b1;
                    we_data[i] = 1'b1;
                end
            end
        end

        n_occ = r_occ;
        if (do_insert && !do_evict) begin
            n_occ = r_occ + OCC_W'(1);
        end else if (do_drop || (is_evict && r_old_ok)) begin
            n_occ = r_occ - OCC_W'(1);
        end

        n_evictions = r_evictions;
        if (do_evict && r_evictions != TOT_MAX) n_evictions = r_evictions + TOT_W'(1);

        res_found = ((is_get || is_remove || is_contains || is_peek) && r_hit)
                    || (is_evict && r_old_ok);
        res_data  = '0;
        if ((is_get || is_peek) && r_hit) begin
            res_data = r_hit_data;
        end else if (is_put && !r_hit && full) begin
            res_data = r_old_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ       <= '0;
            r_evictions <= '0;
            r_cap       <= CAP_RESET;
            for (int i = 0; i < DEPTH; i++) r_valid[i] <= 1'b0;
        end else begin
            if (i_cfg_we) r_cap <= i_cfg_data;
            if (i_cmd.apply) begin
                r_occ       <= n_occ;
                r_evictions <= n_evictions;
                for (int i = 0; i < DEPTH; i++) r_valid[i] <= n_valid[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_op;
            r_key     <= i_key;
            r_payload <= i_payload;
        end
        if (i_cmd.look) begin
            r_hit      <= hit;
            r_hit_idx  <= hit_idx;
            r_hit_age  <= hit_age;
            r_hit_data <= hit_data;
            r_old_ok   <= old_ok;
            r_old_idx  <= old_idx;
            r_old_key  <= old_key;
            r_old_data <= old_data;
            r_free_idx <= free_idx;
        end
        if (i_cmd.apply) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_age[i] <= n_age[i];
                if (we_key[i])  r_skey[i]  <= r_key;
                if (we_data[i]) r_sdata[i] <= r_payload;
            end
            o_found          <= res_found;
            o_data_out       <= res_data;
            o_victim_valid   <= do_evict;
            o_victim_key     <= do_evict ? r_old_key : '0;
            o_occupancy      <= n_occ;
            o_eviction_total <= n_evictions;
        end
    end

endmodule

`default_nettype wire

### rtl/core/lru_keyed_block_store.sv
// lru keyed block store: up to DEPTH key/payload entries kept in least-recently-used order
//
// requests enter on the s_axis channel: tuser carries the operation (put, get, remove,
// contains, evict, peek), tdata the key and the payload. every request gives exactly
// one result on the m_axis channel: tuser holds found and victim_valid, tdata holds
// data_out, victim_key, occupancy and the saturating eviction total.
// a request is handled in the look state, which compares its key against all slots at once and
// finds the oldest and a free slot, then in the apply state, which updates valid marks, ages and
// the result register. apply waits while the previous result is unread, and a new request is
// taken in the same cycle the previous one commits, so requests overlap while the receiver
// keeps up.
// when the result register is still full and m_axis_tready is low, the commit waits
// and s_axis_tready stays low until the result is taken.
// the capacity register is written through i_cfg_we / i_cfg_data; the user must write it only while
// idle, as the block does not enforce it; zero acts as one and values above DEPTH as DEPTH.
// reset clears all valid marks, the occupancy and the eviction total and sets the
// capacity to sixteen; the block is ready as soon as reset is released.
`default_nettype none

module lru_keyed_block_store #(
    parameter  int DEPTH     = 16,
    parameter  int KEY_BITS  = 32,
    parameter  int DATA_BITS = 32,
    localparam int OCC_W     = $clog2(DEPTH + 1),
    localparam int IN_W      = ((KEY_BITS + DATA_BITS + 7) / 8) * 8,
    localparam int OUT_RAW_W = DATA_BITS + KEY_BITS + OCC_W + 32,
    localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_cfg_we,
    input  wire  [lkbs_pkg::CAP_W-1:0]  i_cfg_data,
    input  wire                         s_axis_tvalid,
    output logic                        s_axis_tready,
    // key, payload
    input  wire  [IN_W-1:0]             s_axis_tdata,
    // operation
    input  wire  [lkbs_pkg::OP_W-1:0]   s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  wire                         m_axis_tready,
    // data_out, victim_key, occupancy, eviction_total
    output logic [OUT_W-1:0]            m_axis_tdata,
    // found, victim_valid
    output logic [lkbs_pkg::FLAGS_W-1:0] m_axis_tuser
);
    import lkbs_pkg::*;

    t_cmd                 cmd;
    logic                 found;
    logic [DATA_BITS-1:0] data_out;
    logic                 victim_valid;
    logic [KEY_BITS-1:0]  victim_key;
    logic [OCC_W-1:0]     occupancy;
    logic [TOT_W-1:0]     eviction_total;

    lkbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .o_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .o_cmd       (cmd)
    );

    lkbs_datapath #(
        .DEPTH     (DEPTH),
        .KEY_BITS  (KEY_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_op             (s_axis_tuser),
        .i_key            (s_axis_tdata[KEY_BITS-1:0]),
        .i_payload        (s_axis_tdata[KEY_BITS +: DATA_BITS]),
        .o_found          (found),
        .o_data_out       (data_out),
        .o_victim_valid   (victim_valid),
        .o_victim_key     (victim_key),
        .o_occupancy      (occupancy),
        .o_eviction_total (eviction_total)
    );

    assign m_axis_tdata = OUT_W'({eviction_total, occupancy, victim_key, data_out});
    assign m_axis_tuser = {victim_valid, found};

endmodule

`default_nettype wire

### tb/sv/tb.sv
// self-checking testbench of the lru keyed block store, with its own lru predictor
module tb;
    import lkbs_pkg::*;

    localparam int DEPTH     = 16;
    localparam int IN_W      = 64;
    localparam int OUT_W     = 104;
    localparam int POOL_N    = 24;
    localparam int LONG_HOLD = 80;

    // operation codes the block does not know
    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef enum logic [1:0] {
        STEP_REQ,
        STEP_CFG,
        STEP_SYNC
    } t_step_kind;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_HALF,
        RX_MOSTLY,
        RX_SPARSE
    } t_rx_mode;

    typedef struct packed {
        t_step_kind       kind;
        logic [OP_W-1:0]  op;
        logic [31:0]      key;
        logic [31:0]      pay;
        logic [CAP_W-1:0] cap;
    } t_step;

    typedef struct packed {
        logic        found;
        logic [31:0] data;
        logic        victim;
        logic [31:0] vkey;
        logic [4:0]  occ;
        logic [31:0] total;
    } t_answer;

    logic                 i_clk         = 1'b0;
    logic                 i_rst_n       = 1'b0;
    logic                 i_cfg_we      = 1'b0;
    logic [CAP_W-1:0]     i_cfg_data    = '0;
    logic                 s_axis_tvalid = 1'b0;
    wire                  s_axis_tready;
    // key, payload
    logic [IN_W-1:0]      s_axis_tdata  = '0;
    // operation
    logic [OP_W-1:0]      s_axis_tuser  = '0;
    wire                  m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // data_out, victim_key, occupancy, eviction_total
    wire  [OUT_W-1:0]     m_axis_tdata;
    // found, victim_valid
    wire  [FLAGS_W-1:0]   m_axis_tuser;

    lru_keyed_block_store uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // predicted contents of the store
    logic             line_vld [DEPTH];
    logic [31:0]      line_key [DEPTH];
    logic [31:0]      line_dat [DEPTH];
    int unsigned      line_age [DEPTH];
    logic [31:0]      evict_total;
    logic [CAP_W-1:0] cap_now;

    t_step   pend_q[$];
    t_answer answer_q[$];
    t_step   on_bus;
    int      gap_left   = 0;
    int      burst_left = 0;
    bit      stim_done  = 1'b0;
    int      errors     = 0;
    int      taken      = 0;

    function automatic int unsigned live_count();
        int unsigned n;
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            if (line_vld[i]) n++;
        return n;
    endfunction

    function automatic int slot_of(input logic [31:0] k);
        for (int i = 0; i < DEPTH; i++)
            if (line_vld[i] && line_key[i] == k) return i;
        return -1;
    endfunction

    function automatic int oldest_slot();
        int unsigned n;
        n = live_count();
        if (n == 0) return -1;
        for (int i = 0; i < DEPTH; i++)
            if (line_vld[i] && line_age[i] == n - 1) return i;
        return -1;
    endfunction

    function automatic void make_newest(input int s);
        int unsigned a;
        a = line_age[s];
        for (int i = 0; i < DEPTH; i++)
            if (line_vld[i] && line_age[i] < a) line_age[i]++;
        line_age[s] = 0;
    endfunction

    function automatic void drop_slot(input int s);
        int unsigned a;
        a = line_age[s];
        line_vld[s] = 1'b0;
        for (int i = 0; i < DEPTH; i++)
            if (line_vld[i] && line_age[i] > a) line_age[i]--;
    endfunction

    function automatic void bump_total();
        if (evict_total != TOT_MAX) evict_total++;
    endfunction

    // applies one request to the predicted store and returns the answer it gives
    function automatic t_answer lru_apply(input t_step st);
        t_answer     a;
        int          s;
        int unsigned lim;
        a = '0;
        case (st.op)
            OP_PUT: begin
                s = slot_of(st.key);
                if (s >= 0) begin
                    line_dat[s] = st.pay;
                    make_newest(s);
                end else begin
                    lim = (cap_now == 0) ? 1 : ((cap_now > DEPTH) ? DEPTH : cap_now);
                    // a lowered capacity still only costs one victim per put
                    if (live_count() >= lim) begin
                        s = oldest_slot();
                        if (s >= 0) begin
                            a.victim = 1'b1;
                            a.vkey   = line_key[s];
                            a.data   = line_dat[s];
                            drop_slot(s);
                            bump_total();
                        end
                    end
                    s = -1;
                    for (int i = DEPTH - 1; i >= 0; i--)
                        if (!line_vld[i]) s = i;
                    if (s >= 0) begin
                        for (int i = 0; i < DEPTH; i++)
                            if (line_vld[i]) line_age[i]++;
                        line_vld[s] = 1'b1;
                        line_key[s] = st.key;
                        line_dat[s] = st.pay;
                        line_age[s] = 0;
                    end
                end
            end
            OP_GET: begin
                s = slot_of(st.key);
                if (s >= 0) begin
                    a.found = 1'b1;
                    a.data  = line_dat[s];
                    make_newest(s);
                end
            end
            OP_REMOVE: begin
                s = slot_of(st.key);
                if (s >= 0) begin
                    a.found = 1'b1;
                    drop_slot(s);
                end
            end
            OP_CONTAINS: begin
                a.found = (slot_of(st.key) >= 0);
            end
            OP_EVICT: begin
                s = oldest_slot();
                if (s >= 0) begin
                    a.found  = 1'b1;
                    a.victim = 1'b1;
                    a.vkey   = line_key[s];
                    drop_slot(s);
                    bump_total();
                end
            end
            OP_PEEK: begin
                s = slot_of(st.key);
                if (s >= 0) begin
                    a.found = 1'b1;
                    a.data  = line_dat[s];
                end
            end
            default: begin
            end
        endcase
        a.occ   = 5'(live_count());
        a.total = evict_total;
        return a;
    endfunction

    task automatic report_bad(input string msg);
        errors++;
        $display("mismatch at %0t: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) report_bad($sformatf("%s got %h want %h", name, got, want));
    endtask

    task automatic add_req(input logic [OP_W-1:0] op, input logic [31:0] key,
                           input logic [31:0] pay);
        t_step st;
        st      = '0;
        st.kind = STEP_REQ;
        st.op   = op;
        st.key  = key;
        st.pay  = pay;
        pend_q.insert(pend_q.size(), st);
    endtask

    task automatic add_ctl(input t_step_kind kind, input logic [CAP_W-1:0] v);
        t_step st;
        st      = '0;
        st.kind = kind;
        st.cap  = v;
        pend_q.insert(pend_q.size(), st);
    endtask

    // request driver: bursts of random length, random gaps between them
    always @(posedge i_clk) begin : drive
        logic             nx_valid;
        logic             nx_we;
        logic [IN_W-1:0]  nx_data;
        logic [OP_W-1:0]  nx_user;
        logic [CAP_W-1:0] nx_cfg;
        nx_valid = s_axis_tvalid;
        nx_we    = 1'b0;
        nx_data  = s_axis_tdata;
        nx_user  = s_axis_tuser;
        nx_cfg   = i_cfg_data;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                answer_q.insert(answer_q.size(), lru_apply(on_bus));
                nx_valid = 1'b0;
            end
            if (!nx_valid && pend_q.size() > 0) begin
                if (pend_q[0].kind != STEP_REQ) begin
                    // register writes and syncs wait until every result is back
                    if (answer_q.size() == 0) begin
                        if (pend_q[0].kind == STEP_CFG) begin
                            nx_we   = 1'b1;
                            nx_cfg  = pend_q[0].cap;
                            cap_now = pend_q[0].cap;
                        end
                        void'(pend_q.pop_front());
                    end
                end else if (gap_left > 0) begin
                    gap_left--;
                end else begin
                    on_bus   = pend_q.pop_front();
                    nx_valid = 1'b1;
                    nx_data  = {on_bus.pay, on_bus.key};
                    nx_user  = on_bus.op;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(24, 1);
                        gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(8, 1);
                    end
                end
            end
            if (!nx_valid && pend_q.size() == 0) stim_done = 1'b1;
        end
        s_axis_tvalid <= nx_valid;
        s_axis_tdata  <= nx_data;
        s_axis_tuser  <= nx_user;
        i_cfg_we      <= nx_we;
        i_cfg_data    <= nx_cfg;
    end

    // result receiver: stall pattern of its own plus one long hold-off
    t_rx_mode rx_mode   = RX_OPEN;
    int       mode_left = 0;
    int       hold_left = 0;
    bit       held_once = 1'b0;

    always @(posedge i_clk) begin : accept
        logic nx_ready;
        if (mode_left == 0) begin
            rx_mode   = t_rx_mode'($urandom_range(3, 0));
            mode_left = $urandom_range(80, 10);
        end else begin
            mode_left--;
        end
        // hold off while requests keep coming so that the input backs up
        if (!held_once && taken >= 500 && s_axis_tvalid) begin
            held_once = 1'b1;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            nx_ready = 1'b0;
        end else begin
            case (rx_mode)
                RX_OPEN:   nx_ready = 1'b1;
                RX_HALF:   nx_ready = 1'($urandom_range(1, 0));
                RX_MOSTLY: nx_ready = ($urandom_range(3, 0) != 0);
                default:   nx_ready = ($urandom_range(4, 0) == 0);
            endcase
        end
        m_axis_tready <= nx_ready;
    end

    always @(posedge i_clk) begin : check
        t_answer want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            taken++;
            if (answer_q.size() == 0) begin
                report_bad("result with no request outstanding");
            end else begin
                want = answer_q.pop_front();
                check_field("found", 32'(m_axis_tuser[0]), 32'(want.found));
                check_field("victim_valid", 32'(m_axis_tuser[1]), 32'(want.victim));
                check_field("data_out", m_axis_tdata[31:0], want.data);
                check_field("victim_key", m_axis_tdata[63:32], want.vkey);
                check_field("occupancy", 32'(m_axis_tdata[68:64]), 32'(want.occ));
                check_field("eviction_total", m_axis_tdata[100:69], want.total);
            end
        end
    end

    initial begin : run
        logic [31:0]      pool [POOL_N];
        logic [CAP_W-1:0] caps [12];
        logic [OP_W-1:0]  op;
        logic [31:0]      key;
        logic [31:0]      pay;
        int               n_keys;
        int               n_items;
        int               pick;

        for (int i = 0; i < DEPTH; i++) begin
            line_vld[i] = 1'b0;
            line_key[i] = '0;
            line_dat[i] = '0;
            line_age[i] = 0;
        end
        evict_total = '0;
        cap_now     = CAP_RESET;

        pool[0] = 32'h0000_0000;
        pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_N; i++) pool[i] = $urandom;

        // directed: empty store, extremes, update, unknown codes, small capacities
        add_req(OP_EVICT, 32'h0, 32'h0);
        add_req(OP_GET, 32'h0, 32'h0);
        add_req(OP_PEEK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(OP_CONTAINS, 32'h0, 32'h0);
        add_req(OP_REMOVE, 32'h0, 32'h0);
        add_req(OP_PUT, 32'h0, 32'h0);
        add_req(OP_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(OP_GET, 32'h0, 32'hFFFF_FFFF);
        add_req(OP_PEEK, 32'hFFFF_FFFF, 32'h0);
        add_req(OP_CONTAINS, 32'hFFFF_FFFF, 32'h0);
        add_req(OP_PUT, 32'h0, 32'h5A5A_A5A5);
        add_req(OP_SPARE_A, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(OP_SPARE_B, 32'h0, 32'h0);
        add_req(OP_EVICT, 32'h1234_5678, 32'h0);
        add_req(OP_REMOVE, 32'h0, 32'h0);
        add_req(OP_REMOVE, 32'h0, 32'h0);
        add_ctl(STEP_CFG, 5'd1);
        add_req(OP_PUT, 32'h0000_0001, 32'hA5A5_5A5A);
        add_req(OP_PUT, 32'h0000_0002, 32'h0F0F_F0F0);
        add_req(OP_GET, 32'h0000_0001, 32'h0);
        add_ctl(STEP_CFG, 5'd0);
        add_req(OP_PUT, 32'h0000_0003, 32'hF0F0_0F0F);
        add_ctl(STEP_CFG, 5'd31);
        add_req(OP_PUT, 32'h0000_0004, 32'h1111_1111);
        add_req(OP_PUT, 32'h0000_0005, 32'hEEEE_EEEE);
        add_req(OP_EVICT, 32'h0, 32'h0);

        // random phases, each under its own capacity; 16 then 5 shrinks below occupancy
        caps = '{5'd16, 5'd5, 5'd1, 5'd31, 5'd0, 5'd2, 5'd12, 5'd16, 5'd3, 5'd9,
                 5'd20, 5'd7};
        foreach (caps[p]) begin
            add_ctl(STEP_CFG, caps[p]);
            n_keys  = $urandom_range(POOL_N, 2);
            n_items = $urandom_range(170, 115);
            for (int i = 0; i < n_items; i++) begin
                if (i == n_items / 2) add_ctl(STEP_SYNC, '0);
                pick = $urandom_range(99, 0);
                if (pick < 36)      op = OP_PUT;
                else if (pick < 56) op = OP_GET;
                else if (pick < 66) op = OP_PEEK;
                else if (pick < 74) op = OP_CONTAINS;
                else if (pick < 84) op = OP_REMOVE;
                else if (pick < 94) op = OP_EVICT;
                else if (pick < 97) op = OP_SPARE_A;
                else                op = OP_SPARE_B;
                key = ($urandom_range(9, 0) == 0) ? $urandom
                                                  : pool[$urandom_range(n_keys - 1, 0)];
                pick = $urandom_range(19, 0);
                if (pick == 0)      pay = 32'h0;
                else if (pick == 1) pay = 32'hFFFF_FFFF;
                else                pay = $urandom;
                add_req(op, key, pay);
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (stim_done);
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

    initial begin : watchdog
        #7200000;
        $display("tb: FAIL");
        $finish;
    end

endmodule
